// File: rtl/dtpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtpf_pkg;

    localparam int WORD_W = 32;
    localparam int SKIP_W = 30;
    localparam int STAT_W = 3;

    localparam logic [SKIP_W-1:0] SKIP_MAX = {SKIP_W{1'b1}};

    // structure block tokens
    localparam logic [WORD_W-1:0] TOK_BEGIN    = 32'h0000_0001;
    localparam logic [WORD_W-1:0] TOK_END_NODE = 32'h0000_0002;
    localparam logic [WORD_W-1:0] TOK_PROP     = 32'h0000_0003;
    localparam logic [WORD_W-1:0] TOK_NOP      = 32'h0000_0004;

    // result status codes
    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd1;
    localparam logic [STAT_W-1:0] ST_BADTOK    = 3'd2;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd3;
    localparam logic [STAT_W-1:0] ST_OVERRUN   = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_TOKEN = 3'd1,
        PH_NAME  = 3'd2,
        PH_PLEN  = 3'd3,
        PH_PNAME = 3'd4,
        PH_PDATA = 3'd5,
        PH_AFTER = 3'd6
    } t_phase;

    function automatic logic has_zero_byte(input logic [WORD_W-1:0] w);
        return (w[7:0] == 8'h00) || (w[15:8] == 8'h00) ||
               (w[23:16] == 8'h00) || (w[31:24] == 8'h00);
    endfunction

endpackage

`default_nettype wire

// File: rtl/dtpf_stack.sv
`timescale 1ns / 1ps
`default_nettype none

// node offset stack storage, one write and one registered read port
module dtpf_stack #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 20,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/device_tree_parent_finder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// result path: the word that ends the walk sends its result through the memory read stage, then the output register
// throughput: one structure word per cycle; o_stall rises only while both result
//   registers (memory read stage and output register) hold words and i_stall is high
// reset: synchronous, active low; no walk is active and words are dropped until block start
// reset does not clear the stack memory; the bottom entry is implied as offset 0
module device_tree_parent_finder_core #(
    parameter int MAX_DEPTH   = 16,
    parameter int OFFSET_BITS = 20
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // structure word channel
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic                   i_block_start,
    input  wire logic [OFFSET_BITS-1:0] i_target_offset,
    input  wire logic [31:0]            i_token_word,
    // result channel
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [2:0]                  o_status,
    output logic [OFFSET_BITS-1:0]      o_parent_offset
);

    localparam int TOP_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam logic [TOP_W-1:0] TOP_LAST = TOP_W'(MAX_DEPTH - 1);

    // walk control state
    dtpf_pkg::t_phase                r_phase, n_phase;
    logic [TOP_W-1:0]                r_top, n_top;
    logic [OFFSET_BITS-1:0]          r_pos, n_pos;
    logic [dtpf_pkg::SKIP_W-1:0]     r_skip, n_skip;
    logic [OFFSET_BITS-1:0]          r_sought, n_sought;

    // result pipeline: read stage then output register
    logic                            r_s1_valid;
    logic [dtpf_pkg::STAT_W-1:0]     r_s1_status;
    logic                            r_s1_use_mem;
    logic                            r_out_valid;
    logic [dtpf_pkg::STAT_W-1:0]     r_out_status;
    logic [OFFSET_BITS-1:0]          r_out_parent;

    logic                            accept;
    logic                            res_valid;
    logic [dtpf_pkg::STAT_W-1:0]     res_status;
    logic                            res_use_mem;
    logic                            push;
    logic [OFFSET_BITS-1:0]          push_pos;

    // working copies after a possible block start
    dtpf_pkg::t_phase                ph;
    logic [TOP_W-1:0]                top;
    logic [OFFSET_BITS-1:0]          pos;
    logic [dtpf_pkg::SKIP_W-1:0]     skip;
    logic [OFFSET_BITS-1:0]          sought;
    logic                            at_tgt;
    logic                            boundary;
    logic [32:0]                     len_sum;
    logic [30:0]                     len_words;
    logic [dtpf_pkg::SKIP_W-1:0]     skip_dec;

    logic                            out_free;
    logic                            move;
    logic [OFFSET_BITS-1:0]          rd_data;

    // stall upstream only when no register is left to take a result
    assign o_stall = r_s1_valid && r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        ph     = r_phase;
        top    = r_top;
        pos    = r_pos;
        skip   = r_skip;
        sought = r_sought;
        if (accept && i_block_start) begin
            // new walk; this word is offset 0
            ph     = dtpf_pkg::PH_TOKEN;
            top    = '0;
            pos    = '0;
            skip   = '0;
            sought = i_target_offset;
        end

        n_phase     = r_phase;
        n_top       = r_top;
        n_pos       = r_pos;
        n_skip      = r_skip;
        n_sought    = r_sought;
        res_valid   = 1'b0;
        res_status  = dtpf_pkg::ST_FOUND;
        res_use_mem = 1'b0;
        push        = 1'b0;
        push_pos    = pos;
        at_tgt      = (pos == sought);
        boundary    = 1'b0;
        len_sum     = {1'b0, i_token_word} + 33'd3;
        len_words   = len_sum[32:2];
        skip_dec    = (skip != '0) ? skip - 1'b1 : skip;

        if (accept) begin
            n_phase  = ph;
            n_top    = top;
            n_skip   = skip;
            n_sought = sought;
            n_pos    = pos;
            if (ph != dtpf_pkg::PH_IDLE) begin
                n_pos = pos + OFFSET_BITS'(1);
                case (ph)
                    dtpf_pkg::PH_NAME: begin
                        // node name runs up to the word with a zero byte
                        if (at_tgt) begin
                            res_valid  = 1'b1;
                            res_status = dtpf_pkg::ST_OVERRUN;
                        end else if (dtpf_pkg::has_zero_byte(i_token_word)) begin
                            n_phase = dtpf_pkg::PH_AFTER;
                        end
                    end
                    dtpf_pkg::PH_PLEN: begin
                        if (at_tgt) begin
                            res_valid  = 1'b1;
                            res_status = dtpf_pkg::ST_OVERRUN;
                        end else begin
                            // byte length to data words, saturated
                            n_skip  = len_words[30] ? dtpf_pkg::SKIP_MAX
                                                    : len_words[dtpf_pkg::SKIP_W-1:0];
                            n_phase = dtpf_pkg::PH_PNAME;
                        end
                    end
                    dtpf_pkg::PH_PNAME: begin
                        if (at_tgt) begin
                            res_valid  = 1'b1;
                            res_status = dtpf_pkg::ST_OVERRUN;
                        end else begin
                            n_phase = (skip == '0) ? dtpf_pkg::PH_AFTER
                                                   : dtpf_pkg::PH_PDATA;
                        end
                    end
                    dtpf_pkg::PH_PDATA: begin
                        if (at_tgt) begin
                            res_valid  = 1'b1;
                            res_status = dtpf_pkg::ST_OVERRUN;
                        end else begin
                            n_skip = skip_dec;
                            if (skip_dec == '0) begin
                                n_phase = dtpf_pkg::PH_AFTER;
                            end
                        end
                    end
                    dtpf_pkg::PH_AFTER: begin
                        // properties and no-ops inside a node header are not boundaries
                        if (i_token_word == dtpf_pkg::TOK_PROP ||
                            i_token_word == dtpf_pkg::TOK_NOP) begin
                            if (at_tgt) begin
                                res_valid  = 1'b1;
                                res_status = dtpf_pkg::ST_OVERRUN;
                            end else if (i_token_word == dtpf_pkg::TOK_PROP) begin
                                n_phase = dtpf_pkg::PH_PLEN;
                            end
                        end else begin
                            boundary = 1'b1;
                            n_phase  = dtpf_pkg::PH_TOKEN;
                        end
                    end
                    dtpf_pkg::PH_TOKEN: begin
                        boundary = 1'b1;
                    end
                    default: begin
                    end
                endcase

                if (boundary) begin
                    if (at_tgt) begin
                        // parent is the stack top; bottom entry reads as 0
                        res_valid   = 1'b1;
                        res_status  = dtpf_pkg::ST_FOUND;
                        res_use_mem = (top != '0);
                    end else if (i_token_word == dtpf_pkg::TOK_BEGIN) begin
                        if (top == TOP_LAST) begin
                            res_valid  = 1'b1;
                            res_status = dtpf_pkg::ST_OVERFLOW;
                        end else begin
                            n_top   = top + 1'b1;
                            push    = 1'b1;
                            n_phase = dtpf_pkg::PH_NAME;
                        end
                    end else if (i_token_word == dtpf_pkg::TOK_END_NODE) begin
                        if (top == '0) begin
                            res_valid  = 1'b1;
                            res_status = dtpf_pkg::ST_UNDERFLOW;
                        end else begin
                            n_top = top - 1'b1;
                        end
                    end else if (i_token_word != dtpf_pkg::TOK_NOP) begin
                        res_valid  = 1'b1;
                        res_status = dtpf_pkg::ST_BADTOK;
                    end
                end

                // every status ends the walk
                if (res_valid) begin
                    n_phase = dtpf_pkg::PH_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= dtpf_pkg::PH_IDLE;
            r_top    <= '0;
            r_pos    <= '0;
            r_skip   <= '0;
            r_sought <= '0;
        end else begin
            r_phase  <= n_phase;
            r_top    <= n_top;
            r_pos    <= n_pos;
            r_skip   <= n_skip;
            r_sought <= n_sought;
        end
    end

    // stack memory: a push writes the new top entry, a found reads the current top.
    // the walk ends on a found, so a read never meets a write to the same entry
    dtpf_stack #(
        .DEPTH (MAX_DEPTH),
        .WIDTH (OFFSET_BITS),
        .AW    (TOP_W)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (push),
        .i_wr_addr (n_top),
        .i_wr_data (push_pos),
        .i_rd_en   (res_valid && res_use_mem),
        .i_rd_addr (top),
        .o_rd_data (rd_data)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign move     = r_s1_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (res_valid) begin
                r_s1_valid <= 1'b1;
            end else if (move) begin
                r_s1_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_s1_status  <= res_status;
            r_s1_use_mem <= res_use_mem;
        end
        if (move) begin
            r_out_status <= r_s1_status;
            r_out_parent <= r_s1_use_mem ? rd_data : '0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_parent_offset = r_out_parent;

endmodule

`default_nettype wire

// File: rtl/dtpf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dtpf_checker #(
    parameter int OFFSET_BITS = 20
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_stall,
    input wire logic                   o_valid,
    input wire logic                   i_stall,
    input wire logic [2:0]             o_status,
    input wire logic [OFFSET_BITS-1:0] o_parent_offset
);

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_parent_offset))
        else $error("result word changed under stall");

    // status codes stop at offset overrun
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == dtpf_pkg::ST_FOUND || o_status == dtpf_pkg::ST_OVERFLOW ||
                     o_status == dtpf_pkg::ST_BADTOK || o_status == dtpf_pkg::ST_UNDERFLOW ||
                     o_status == dtpf_pkg::ST_OVERRUN))
        else $error("bad status code");

    // parent offset only carried with a found status
    a_parent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != dtpf_pkg::ST_FOUND |-> o_parent_offset == '0)
        else $error("parent offset set on an error status");

    // upstream stall only while a result word waits
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall with no pending result");

    // reset empties the result path
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result path not empty after reset");

endmodule

bind device_tree_parent_finder_core dtpf_checker #(
    .OFFSET_BITS (OFFSET_BITS)
) u_dtpf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_status        (o_status),
    .o_parent_offset (o_parent_offset)
);

`default_nettype wire
